### design/vsl_pkg.sv
// Shared constants and types for the vector speed limiter.
package vsl_pkg;

    localparam int DEF_COMPONENT_WIDTH = 32;
    localparam int NUM_LANES = 3;
    localparam int SPEED_W = 31;
    localparam int INFL_W = 17;
    localparam int TOL_W = 16;
    localparam int INFL_FRAC = 16;
    localparam int FACTOR_W = SPEED_W + INFL_W;
    localparam int SPLIT_W = FACTOR_W / 2;
    localparam int IDX_W = 2;

    localparam logic [INFL_W-1:0] INFL_RESET = 17'd65536;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_MAX  = 2'd1,
        ADJ_MIN  = 2'd2
    } adj_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_SPEED = 2'd0,
        REG_MAX_SPEED = 2'd1,
        REG_INFLUENCE = 2'd2,
        REG_ZERO_TOL  = 2'd3
    } cfg_reg_t;

endpackage

### design/vsl_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
module vsl_sqrt
    import vsl_pkg::*;
#(
    parameter int N = 33,
    parameter int SIDE_W = 96
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*N-1:0]      rad,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [N-1:0]        root,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int RW = N + 3;

    logic [RW-1:0]     rem_reg  [1:N];
    logic [N-1:0]      root_reg [1:N];
    logic [2*N-1:0]    rad_reg  [1:N];
    logic [SIDE_W-1:0] side_reg [1:N];
    logic              vld_reg  [1:N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW-1:0]     rem_in;
        logic [N-1:0]      root_in;
        logic [2*N-1:0]    rad_in;
        logic [SIDE_W-1:0] side_i;
        logic              vld_in;
        logic [RW-1:0]     cand;
        logic [RW-1:0]     trial;
        logic              ge;
        logic [RW-1:0]     rem_next;
        logic [N-1:0]      root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign side_i  = side_in;
            assign vld_in  = in_valid;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign rad_in  = rad_reg[k];
            assign side_i  = side_reg[k];
            assign vld_in  = vld_reg[k];
        end

        always_comb
        begin
            cand      = {rem_in[RW-3:0], rad_in[2*N-1 -: 2]};
            trial     = {1'b0, root_in, 2'b01};
            ge        = (cand >= trial);
            rem_next  = ge ? (cand - trial) : cand;
            root_next = {root_in[N-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                rad_reg[k+1]  <= {rad_in[2*N-3:0], 2'b00};
                side_reg[k+1] <= side_i;
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign root      = root_reg[N];
    assign side_out  = side_reg[N];

endmodule

### design/vsl_div.sv
// Pipelined restoring divider for three lanes sharing one divisor.
module vsl_div
    import vsl_pkg::*;
#(
    parameter int Q = 33,
    parameter int DW = 49,
    parameter int SIDE_W = 110
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_LANES-1:0][DW-1:0]  rem_in,
    input  logic [NUM_LANES-1:0][Q-1:0]   lo_in,
    input  logic [DW-1:0]                 den,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [NUM_LANES-1:0][Q-1:0]   quo,
    output logic [SIDE_W-1:0]             side_out
);

    logic [NUM_LANES-1:0][DW-1:0] rem_reg  [1:Q];
    logic [NUM_LANES-1:0][Q-1:0]  lo_reg   [1:Q];
    logic [DW-1:0]                den_reg  [1:Q];
    logic [SIDE_W-1:0]            side_reg [1:Q];
    logic                         vld_reg  [1:Q];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [NUM_LANES-1:0][DW-1:0] r_in;
        logic [NUM_LANES-1:0][Q-1:0]  l_in;
        logic [DW-1:0]                d_in;
        logic [SIDE_W-1:0]            s_in;
        logic                         v_in;
        logic [NUM_LANES-1:0][DW-1:0] r_next;
        logic [NUM_LANES-1:0][Q-1:0]  l_next;

        if (k == 0) begin : g_first
            assign r_in = rem_in;
            assign l_in = lo_in;
            assign d_in = den;
            assign s_in = side_in;
            assign v_in = in_valid;
        end
        else begin : g_rest
            assign r_in = rem_reg[k];
            assign l_in = lo_reg[k];
            assign d_in = den_reg[k];
            assign s_in = side_reg[k];
            assign v_in = vld_reg[k];
        end

        always_comb
        begin
            logic [DW:0] cand;
            logic [DW:0] diff;
            logic        ge;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                cand      = {r_in[i], l_in[i][Q-1]};
                diff      = cand - {1'b0, d_in};
                ge        = (cand >= {1'b0, d_in});
                r_next[i] = ge ? diff[DW-1:0] : cand[DW-1:0];
                l_next[i] = {l_in[i][Q-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= r_next;
                lo_reg[k+1]   <= l_next;
                den_reg[k+1]  <= d_in;
                side_reg[k+1] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[Q];
    assign quo       = lo_reg[Q];
    assign side_out  = side_reg[Q];

endmodule

### design/vector_speed_limiter.sv
// Throughput: one word per cycle while the output is not stalled.
// The square root and the divider each retire one bit per stage.
// A stalled result holds the whole pipeline, so the input stalls while the output is stalled.
// Reset clears the valid bits and loads the registers: both speeds zero, influence one,
// zero tolerance one.
module vector_speed_limiter
    import vsl_pkg::*;
#(
    parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vel_valid,
    output logic                               vel_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]  vel_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  vel_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  vel_z,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic signed [COMPONENT_WIDTH-1:0]  out_x,
    output logic signed [COMPONENT_WIDTH-1:0]  out_y,
    output logic signed [COMPONENT_WIDTH-1:0]  out_z,
    output logic [1:0]                         adjusted,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [IDX_W-1:0]                   cfg_index,
    input  logic [31:0]                        cfg_data
);

    localparam int W = COMPONENT_WIDTH;
    localparam int N = W + 1;
    localparam int Q = N;
    localparam int DW = N + INFL_FRAC;
    localparam int NW = W + FACTOR_W + 1;
    localparam int CMP_W = (N > SPEED_W) ? N : SPEED_W;
    localparam int VSIDE_W = NUM_LANES * W;
    localparam int DSIDE_W = 2 + VSIDE_W + 2 * NUM_LANES;
    localparam logic [Q-1:0] SIGN_Q = {{(Q-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [Q-1:0] POS_MAX_Q = SIGN_Q - 1'b1;

    typedef logic [NUM_LANES-1:0][W-1:0] lane_vec_t;

    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic [INFL_W-1:0]  influence_reg;
    logic [TOL_W-1:0]   zero_tol_reg;

    logic en;

    lane_vec_t                        v1_reg, mag1_reg;
    logic                             vld1_reg;
    logic [NUM_LANES-1:0][2*W-1:0]    sq2_reg;
    lane_vec_t                        v2_reg;
    logic                             vld2_reg;
    logic [2*N-1:0]                   sum3_reg;
    lane_vec_t                        v3_reg;
    logic                             vld3_reg;

    logic                             sq_valid;
    logic [N-1:0]                     sq_len;
    logic [VSIDE_W-1:0]               sq_side;

    lane_vec_t                        v4_reg, mag4_reg;
    adj_t                             mode4_reg;
    logic [FACTOR_W-1:0]              factor4_reg;
    logic [DW-1:0]                    den4_reg;
    logic                             vld4_reg;

    logic [NUM_LANES-1:0][W+SPLIT_W-1:0]            pl5_reg;
    logic [NUM_LANES-1:0][W+FACTOR_W-SPLIT_W-1:0]   ph5_reg;
    lane_vec_t                        v5_reg;
    adj_t                             mode5_reg;
    logic [DW-1:0]                    den5_reg;
    logic                             vld5_reg;

    logic [NUM_LANES-1:0][NW-1:0]     num6_reg;
    lane_vec_t                        v6_reg;
    adj_t                             mode6_reg;
    logic [DW-1:0]                    den6_reg;
    logic                             vld6_reg;

    logic [NUM_LANES-1:0][DW-1:0]     rem7_reg;
    logic [NUM_LANES-1:0][Q-1:0]      lo7_reg;
    logic [NUM_LANES-1:0]             over7_reg, neg7_reg;
    lane_vec_t                        v7_reg;
    adj_t                             mode7_reg;
    logic [DW-1:0]                    den7_reg;
    logic                             vld7_reg;

    logic                             dv_valid;
    logic [NUM_LANES-1:0][Q-1:0]      dv_quo;
    logic [DSIDE_W-1:0]               dv_side;

    lane_vec_t                        res_reg;
    adj_t                             adj_reg;
    logic                             vld8_reg;

    lane_vec_t                        vin;
    lane_vec_t                        mag_in;
    lane_vec_t                        v4_next, mag4_next;
    adj_t                             mode4_next;
    logic [SPEED_W-1:0]               target4;
    lane_vec_t                        res_next;

    assign en        = !(vld8_reg && res_stall);
    assign vel_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg <= '0;
            max_speed_reg <= '0;
            influence_reg <= INFL_RESET;
            zero_tol_reg  <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_SPEED: min_speed_reg <= cfg_data[SPEED_W-1:0];
                REG_MAX_SPEED: max_speed_reg <= cfg_data[SPEED_W-1:0];
                REG_INFLUENCE: influence_reg <= cfg_data[INFL_W-1:0];
                REG_ZERO_TOL:  zero_tol_reg  <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vel_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= sq_valid;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            vld7_reg <= vld6_reg;
            vld8_reg <= dv_valid;
        end
    end

    assign vin = {vel_z, vel_y, vel_x};

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            mag_in[i] = vin[i][W-1] ? (~vin[i] + 1'b1) : vin[i];
        end
    end

    // Squares, their sum, and then the root of the sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg   <= vin;
            mag1_reg <= mag_in;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                sq2_reg[i] <= mag1_reg[i] * mag1_reg[i];
            end
            v2_reg   <= v1_reg;
            sum3_reg <= (2*N)'(sq2_reg[0]) + (2*N)'(sq2_reg[1]) + (2*N)'(sq2_reg[2]);
            v3_reg   <= v2_reg;
        end
    end

    vsl_sqrt #(
        .N      (N),
        .SIDE_W (VSIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld3_reg),
        .rad       (sum3_reg),
        .side_in   (v3_reg),
        .out_valid (sq_valid),
        .root      (sq_len),
        .side_out  (sq_side)
    );

    always_comb
    begin
        v4_next = sq_side;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            mag4_next[i] = v4_next[i][W-1] ? (~v4_next[i] + 1'b1) : v4_next[i];
        end
        if ((max_speed_reg != '0) && (CMP_W'(sq_len) > CMP_W'(max_speed_reg)))
        begin
            mode4_next = ADJ_MAX;
        end
        else if ((min_speed_reg != '0) && (CMP_W'(sq_len) > CMP_W'(zero_tol_reg))
                 && (CMP_W'(sq_len) < CMP_W'(min_speed_reg)))
        begin
            mode4_next = ADJ_MIN;
        end
        else
        begin
            mode4_next = ADJ_NONE;
        end
        target4 = (mode4_next == ADJ_MIN) ? min_speed_reg : max_speed_reg;
    end

    // Scale each component by target times influence over the length, rounded.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v4_reg      <= v4_next;
            mag4_reg    <= mag4_next;
            mode4_reg   <= mode4_next;
            factor4_reg <= target4 * influence_reg;
            den4_reg    <= {sq_len, {INFL_FRAC{1'b0}}};

            for (int i = 0; i < NUM_LANES; i++)
            begin
                pl5_reg[i] <= mag4_reg[i] * factor4_reg[SPLIT_W-1:0];
                ph5_reg[i] <= mag4_reg[i] * factor4_reg[FACTOR_W-1:SPLIT_W];
            end
            v5_reg    <= v4_reg;
            mode5_reg <= mode4_reg;
            den5_reg  <= den4_reg;

            for (int i = 0; i < NUM_LANES; i++)
            begin
                num6_reg[i] <= NW'(pl5_reg[i]) + (NW'(ph5_reg[i]) << SPLIT_W)
                               + NW'(den5_reg >> 1);
            end
            v6_reg    <= v5_reg;
            mode6_reg <= mode5_reg;
            den6_reg  <= den5_reg;

            for (int i = 0; i < NUM_LANES; i++)
            begin
                over7_reg[i] <= (num6_reg[i] >> Q) >= NW'(den6_reg);
                rem7_reg[i]  <= DW'(num6_reg[i] >> Q);
                lo7_reg[i]   <= num6_reg[i][Q-1:0];
                neg7_reg[i]  <= v6_reg[i][W-1];
            end
            v7_reg    <= v6_reg;
            mode7_reg <= mode6_reg;
            den7_reg  <= den6_reg;
        end
    end

    vsl_div #(
        .Q      (Q),
        .DW     (DW),
        .SIDE_W (DSIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld7_reg),
        .rem_in    (rem7_reg),
        .lo_in     (lo7_reg),
        .den       (den7_reg),
        .side_in   ({mode7_reg, v7_reg, neg7_reg, over7_reg}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    always_comb
    begin
        adj_t                 d_mode;
        lane_vec_t            d_v;
        logic [NUM_LANES-1:0] d_neg;
        logic [NUM_LANES-1:0] d_over;
        logic [Q-1:0]         qneg;
        {d_mode, d_v, d_neg, d_over} = dv_side;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            qneg = '0 - dv_quo[i];
            if (d_mode == ADJ_NONE)
            begin
                res_next[i] = d_v[i];
            end
            else if (d_neg[i])
            begin
                res_next[i] = (d_over[i] || (dv_quo[i] > SIGN_Q)) ?
                              SIGN_Q[W-1:0] : qneg[W-1:0];
            end
            else
            begin
                res_next[i] = (d_over[i] || (dv_quo[i] > POS_MAX_Q)) ?
                              POS_MAX_Q[W-1:0] : dv_quo[i][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            adj_reg <= adj_t'(dv_side[DSIDE_W-1 -: 2]);
        end
    end

    assign res_valid = vld8_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign adjusted  = adj_reg;

endmodule

### design/vsl_checker.sv
// Port-level assertions for the vector speed limiter, bound to the top level.
module vsl_checker
    import vsl_pkg::*;
#(
    parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               vel_valid,
    input logic                               vel_stall,
    input logic signed [COMPONENT_WIDTH-1:0]  vel_x,
    input logic signed [COMPONENT_WIDTH-1:0]  vel_y,
    input logic signed [COMPONENT_WIDTH-1:0]  vel_z,
    input logic                               res_valid,
    input logic                               res_stall,
    input logic signed [COMPONENT_WIDTH-1:0]  out_x,
    input logic signed [COMPONENT_WIDTH-1:0]  out_y,
    input logic signed [COMPONENT_WIDTH-1:0]  out_z,
    input logic [1:0]                         adjusted,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [IDX_W-1:0]                   cfg_index,
    input logic [31:0]                        cfg_data
);

    // The input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        vel_stall |-> (res_valid && res_stall))
        else $error("input stalled without a stalled result");

    a_adj_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (adjusted == ADJ_NONE || adjusted == ADJ_MAX || adjusted == ADJ_MIN))
        else $error("result carries an unknown adjust code");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(out_x) && $stable(out_y)
                                      && $stable(out_z) && $stable(adjusted)))
        else $error("stalled result changed");

    // A result can never appear out of nothing right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind vector_speed_limiter vsl_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_vsl_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for the vector speed limiter: directed table, then random vectors.
`timescale 1ns / 1ps

module tb;
    import vsl_pkg::*;

    localparam int CW = DEF_COMPONENT_WIDTH;
    localparam int LATENCY = 2 * CW + 10;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        adj_t          adj;
    } vec_result_t;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        bit            typed;
        vec_result_t   want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic vel_valid = 1'b0;
    logic vel_stall;
    logic signed [CW-1:0] vel_x = '0;
    logic signed [CW-1:0] vel_y = '0;
    logic signed [CW-1:0] vel_z = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic [1:0] adjusted;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [SPEED_W-1:0] lim_min;
    logic [SPEED_W-1:0] lim_max;
    logic [INFL_W-1:0] lim_infl;
    logic [TOL_W-1:0] lim_tol;

    vec_result_t pending_results[$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    vector_speed_limiter dut (.*);

    always #5 clk = ~clk;

    function automatic logic [CW-1:0] rescale_comp(logic [CW-1:0] raw,
                                                   logic [127:0] factor,
                                                   logic [127:0] den);
        logic neg;
        logic [127:0] mag;
        logic [127:0] q;
        neg = raw[CW-1];
        mag = neg ? {96'd0, -raw} : {96'd0, raw};
        q = (mag * factor + (den >> 1)) / den;
        if (neg)
        begin
            if (q > (128'd1 << (CW - 1)))
                q = 128'd1 << (CW - 1);
            return -q[CW-1:0];
        end
        if (q > (128'd1 << (CW - 1)) - 1)
            q = (128'd1 << (CW - 1)) - 1;
        return q[CW-1:0];
    endfunction

    function automatic vec_result_t limit_speed(logic [CW-1:0] x, logic [CW-1:0] y,
                                                logic [CW-1:0] z);
        vec_result_t r;
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] az;
        logic [127:0] sum;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] target;
        ax = x[CW-1] ? {96'd0, -x} : {96'd0, x};
        ay = y[CW-1] ? {96'd0, -y} : {96'd0, y};
        az = z[CW-1] ? {96'd0, -z} : {96'd0, z};
        sum = ax * ax + ay * ay + az * az;
        root = 0;
        for (int b = CW; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum)
                root = cand;
        end
        r.adj = ADJ_NONE;
        target = 0;
        if (lim_max != 0 && root > lim_max)
        begin
            r.adj = ADJ_MAX;
            target = lim_max;
        end
        else if (lim_min != 0 && root > lim_tol && root < lim_min)
        begin
            r.adj = ADJ_MIN;
            target = lim_min;
        end
        if (r.adj == ADJ_NONE)
        begin
            r.x = x;
            r.y = y;
            r.z = z;
        end
        else
        begin
            r.x = rescale_comp(x, target * lim_infl, root << INFL_FRAC);
            r.y = rescale_comp(y, target * lim_infl, root << INFL_FRAC);
            r.z = rescale_comp(z, target * lim_infl, root << INFL_FRAC);
        end
        return r;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_SPEED: lim_min = value[SPEED_W-1:0];
            REG_MAX_SPEED: lim_max = value[SPEED_W-1:0];
            REG_INFLUENCE: lim_infl = value[INFL_W-1:0];
            REG_ZERO_TOL:  lim_tol = value[TOL_W-1:0];
        endcase
    endtask

    task automatic set_limits(logic [31:0] mn, logic [31:0] mx, logic [31:0] infl,
                              logic [31:0] tol);
        write_reg(REG_MIN_SPEED, mn);
        write_reg(REG_MAX_SPEED, mx);
        write_reg(REG_INFLUENCE, infl);
        write_reg(REG_ZERO_TOL, tol);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               bit typed, vec_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vel_valid <= 1'b0;
            @(posedge clk);
        end
        vel_valid <= 1'b1;
        vel_x <= x;
        vel_y <= y;
        vel_z <= z;
        pending_results.push_back(typed ? want : limit_speed(x, y, z));
        @(posedge clk);
        while (vel_stall)
            @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? $urandom_range(0, 3) : -$urandom_range(1, 3);
            2: return {{(CW-21){$urandom_range(0, 1) == 1}}, 21'($urandom)};
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(CW-1){1'b0}}} |
                      ($urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : '0);
            default: return {{(CW-18){$urandom_range(0, 1) == 1}}, 18'($urandom)};
        endcase
    endfunction

    task automatic random_phase(int count);
        vec_result_t unused;
        unused = '{default: '0, adj: ADJ_NONE};
        for (int i = 0; i < count; i++)
            send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, unused);
        vel_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        vec_result_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word x=%h y=%h z=%h adj=%0d", $time,
                         out_x, out_y, out_z, adjusted);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z || adjusted !== e.adj)
                begin
                    $display("%0t: expected x=%h y=%h z=%h adj=%0d, got x=%h y=%h z=%h adj=%0d",
                             $time, e.x, e.y, e.z, e.adj, out_x, out_y, out_z, adjusted);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((vel_valid && !vel_stall) || (res_valid && !res_stall) || pending_results.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
        localparam logic [CW-1:0] MAXN = {1'b1, {(CW-1){1'b0}}};
        lim_min = '0;
        lim_max = '0;
        lim_infl = INFL_RESET;
        lim_tol = TOL_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits are both off, so every word passes through.
        rows.push_back('{'0, '0, '0, 1, '{'0, '0, '0, ADJ_NONE}});
        rows.push_back('{MAXP, MAXN, '1, 1, '{MAXP, MAXN, '1, ADJ_NONE}});
        rows.push_back('{MAXN, MAXN, MAXN, 1, '{MAXN, MAXN, MAXN, ADJ_NONE}});
        foreach (rows[i])
            send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
        vel_valid <= 1'b0;
        drain();

        // Cap at 1.0 and floor at 2.0 with unit influence: an axis vector lands exactly on the limit.
        set_limits(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0100);
        rows.delete();
        rows.push_back('{32'h0005_0000, '0, '0, 1, '{32'h0001_0000, '0, '0, ADJ_MAX}});
        rows.push_back('{'0, -32'sh0005_0000, '0, 1, '{'0, -32'sh0001_0000, '0, ADJ_MAX}});
        rows.push_back('{'0, '0, 32'h0000_8000, 1, '{'0, '0, 32'h0002_0000, ADJ_MIN}});
        rows.push_back('{32'h0000_0100, '0, '0, 1, '{32'h0000_0100, '0, '0, ADJ_NONE}});
        rows.push_back('{32'h0000_0101, '0, '0, 0, '{default: '0, adj: ADJ_NONE}});
        rows.push_back('{MAXP, MAXN, MAXP, 0, '{default: '0, adj: ADJ_NONE}});
        rows.push_back('{32'h0000_0003, -32'sh0000_0004, 32'h0000_0000, 0,
                         '{default: '0, adj: ADJ_NONE}});
        foreach (rows[i])
            send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
        vel_valid <= 1'b0;
        drain();

        // Extremes: top limits, influence above one, zero influence, zero tolerance.
        set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF, 32'h0000_0000);
        rows.delete();
        rows.push_back('{MAXP, MAXP, MAXP, 0, '{default: '0, adj: ADJ_NONE}});
        rows.push_back('{32'h0000_0001, '0, '0, 0, '{default: '0, adj: ADJ_NONE}});
        rows.push_back('{MAXN, '0, '0, 0, '{default: '0, adj: ADJ_NONE}});
        rows.push_back('{'0, '0, '0, 1, '{'0, '0, '0, ADJ_NONE}});
        foreach (rows[i])
            send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
        vel_valid <= 1'b0;
        drain();
        set_limits(32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF);
        rows.delete();
        rows.push_back('{32'h0001_0000, '0, '0, 1, '{'0, '0, '0, ADJ_MIN}});
        rows.push_back('{32'h0000_FFFF, '0, '0, 1, '{32'h0000_FFFF, '0, '0, ADJ_NONE}});
        rows.push_back('{32'hFFFF_0000, 32'h0003_0000, '0, 0, '{default: '0, adj: ADJ_NONE}});
        foreach (rows[i])
            send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
        vel_valid <= 1'b0;
        drain();

        send_idle_pct = 16;
        recv_idle_pct = 69;
        set_limits(32'h0004_0000, 32'h0040_0000, 32'h0000_C000, 32'h0000_0010);
        random_phase(300);
        drain();
        set_limits($urandom_range(1, 32'h0010_0000), $urandom_range(32'h0010_0000, 32'h7FFF_FFFF),
                   $urandom_range(0, 32'h0001_FFFF), $urandom_range(0, 32'hFFFF));
        random_phase(300);
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 16;
        set_limits(32'h0100_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0001);
        random_phase(300);
        drain();
        set_limits(32'h0000_0000, 32'h0000_0400, 32'h0001_FFFF, 32'h0000_0000);
        random_phase(300);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_FFFF);
        random_phase(300);
        drain();
        set_limits($urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
                   $urandom_range(0, 32'h0001_FFFF), $urandom_range(0, 32'hFFFF));
        random_phase(300);
        drain();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
